@@ rtl/core/unix_time_date_converter_macros.svh @@
// Assertion macros for the unix time / date converter checker.
// No dependencies.
`ifndef UNIX_TIME_DATE_CONVERTER_MACROS_SVH
`define UNIX_TIME_DATE_CONVERTER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define UTDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define UTDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/utdc_pkg.sv @@
// Shared constants and calendar functions for the unix time / date converter.
// No dependencies.
package utdc_pkg;

   localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
   localparam logic [16:0] EPOCH_LEAP_DAYS  = 17'd477;
   localparam int          LATENCY          = 5;

   typedef enum logic {
      CMD_DATE_TO_SECS = 1'b0,
      CMD_SECS_TO_DATE = 1'b1
   } cmd_type;

   // floor(x / 100) for x below 4096, by reciprocal
   function automatic logic [11:0] div100(input logic [11:0] x);
      logic [27:0] p;
      p = {16'd0, x} * 28'd41944;
      return {6'd0, p[27:22]};
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      logic [11:0] q;
      logic [11:0] r;
      q = div100(y);
      r = y - 12'(q * 12'd100);
      return ((y[1:0] == 2'd0) && (r != 12'd0)) || ((q[1:0] == 2'd0) && (r == 12'd0));
   endfunction

   // Day number of 1 January of year EPOCH_YEAR + k
   function automatic logic [16:0] year_start(input logic [7:0] k);
      logic [11:0] y;
      logic [11:0] a;
      logic [11:0] q;
      logic [11:0] l;
      y = EPOCH_YEAR + {4'd0, k};
      a = y - 12'd1;
      q = div100(a);
      l = {2'd0, a[11:2]} - q + {2'd0, q[11:2]};
      return 17'({9'd0, k} * 17'd365) + {5'd0, l} - EPOCH_LEAP_DAYS;
   endfunction

   // Days before the first of month index m (0 = January, 12 = full year)
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
      logic [8:0] d;
      unique case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd365;
      endcase
      if (lp && (m >= 4'd2)) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

endpackage

@@ rtl/core/unix_time_date_converter.sv @@
// Unix time / Gregorian date converter, top level.
// Depends on utdc_pkg, utdc_d2s and utdc_s2d.
//
// Takes one request per clock (busy is always low) and returns each result
// on a one-cycle rsp_valid strobe; the receiver cannot stall. The result
// passes through the five register stages of the seconds-to-date path; the
// date-to-seconds path is padded to match.
// Result fields that do not belong to the requested direction read as zero.
module unix_time_date_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_in_timestamp,
   input  logic [11:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [5:0]  req_in_second,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_timestamp,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second
);
   import utdc_pkg::*;

   logic [LATENCY-1:0] valid_ff, valid_in;
   logic [LATENCY-1:0] cmd_ff;
   logic [31:0] d2s_ts;
   logic [11:0] s2d_year;
   logic [3:0]  s2d_month;
   logic [4:0]  s2d_day, s2d_hour;
   logic [5:0]  s2d_minute, s2d_second;
   logic        to_date;

   assign busy = 1'b0;
   assign valid_in = {valid_ff[LATENCY-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= {cmd_ff[LATENCY-2:0], req_command};
   end

   utdc_d2s u_d2s (
      .clock     (clock),
      .year      (req_in_year),
      .month     (req_in_month),
      .day       (req_in_day),
      .hour      (req_in_hour),
      .minute    (req_in_minute),
      .second    (req_in_second),
      .timestamp (d2s_ts)
   );

   utdc_s2d u_s2d (
      .clock     (clock),
      .timestamp (req_in_timestamp),
      .year      (s2d_year),
      .month     (s2d_month),
      .day       (s2d_day),
      .hour      (s2d_hour),
      .minute    (s2d_minute),
      .second    (s2d_second)
   );

   assign to_date = (cmd_ff[LATENCY-1] == CMD_SECS_TO_DATE);

   assign rsp_valid         = valid_ff[LATENCY-1];
   assign rsp_out_timestamp = to_date ? 32'd0 : d2s_ts;
   assign rsp_out_year      = to_date ? s2d_year : 12'd0;
   assign rsp_out_month     = to_date ? s2d_month : 4'd0;
   assign rsp_out_day       = to_date ? s2d_day : 5'd0;
   assign rsp_out_hour      = to_date ? s2d_hour : 5'd0;
   assign rsp_out_minute    = to_date ? s2d_minute : 6'd0;
   assign rsp_out_second    = to_date ? s2d_second : 6'd0;
endmodule

@@ rtl/core/utdc_d2s.sv @@
// Date to seconds datapath, five register stages.
// Depends on utdc_pkg.
module utdc_d2s (
   input  logic        clock,
   input  logic [11:0] year,
   input  logic [3:0]  month,
   input  logic [4:0]  day,
   input  logic [4:0]  hour,
   input  logic [5:0]  minute,
   input  logic [5:0]  second,
   output logic [31:0] timestamp
);
   import utdc_pkg::*;

   // stage A
   logic [11:0] year_a_ff, q100a_a_ff, q100y_a_ff;
   logic [3:0]  month_a_ff;
   logic [4:0]  day_a_ff, hour_a_ff;
   logic [5:0]  minute_a_ff, second_a_ff;
   // stage B
   logic [31:0] days_b_ff, days_b_in;
   logic [4:0]  hour_b_ff;
   logic [5:0]  minute_b_ff, second_b_ff;
   // stages C to E
   logic [31:0] secs_c_ff, secs_c_in, secs_d_ff, secs_e_ff;

   always_ff @(posedge clock) begin
      year_a_ff   <= year;
      q100a_a_ff  <= div100(year - 12'd1);
      q100y_a_ff  <= div100(year);
      month_a_ff  <= month;
      day_a_ff    <= day;
      hour_a_ff   <= hour;
      minute_a_ff <= minute;
      second_a_ff <= second;
   end

   always_comb begin
      logic [11:0] a;
      logic [11:0] l;
      logic [11:0] r;
      logic [31:0] dy;
      logic        lp;
      logic [3:0]  full;
      a  = year_a_ff - 12'd1;
      l  = {2'd0, a[11:2]} - q100a_a_ff + {2'd0, q100a_a_ff[11:2]};
      if (year_a_ff <= EPOCH_YEAR) begin
         dy = 32'd0;
      end else begin
         dy = 32'({20'd0, year_a_ff - EPOCH_YEAR} * 32'd365) + {20'd0, l} - 32'd477;
      end
      r  = year_a_ff - 12'(q100y_a_ff * 12'd100);
      lp = ((year_a_ff[1:0] == 2'd0) && (r != 12'd0)) ||
           ((q100y_a_ff[1:0] == 2'd0) && (r == 12'd0));
      if (month_a_ff == 4'd0) begin
         full = 4'd0;
      end else if (month_a_ff > 4'd13) begin
         full = 4'd12;
      end else begin
         full = month_a_ff - 4'd1;
      end
      days_b_in = dy + {23'd0, month_start(full, lp)} + {27'd0, day_a_ff} - 32'd1;
   end

   always_ff @(posedge clock) begin
      days_b_ff   <= days_b_in;
      hour_b_ff   <= hour_a_ff;
      minute_b_ff <= minute_a_ff;
      second_b_ff <= second_a_ff;
   end

   assign secs_c_in = days_b_ff * 32'd86400 + {27'd0, hour_b_ff} * 32'd3600
                    + {26'd0, minute_b_ff} * 32'd60 + {26'd0, second_b_ff};

   always_ff @(posedge clock) begin
      secs_c_ff <= secs_c_in;
      secs_d_ff <= secs_c_ff;
      secs_e_ff <= secs_d_ff;
   end

   assign timestamp = secs_e_ff;
endmodule

@@ rtl/core/utdc_s2d.sv @@
// Seconds to date datapath, five register stages.
// Depends on utdc_pkg.
module utdc_s2d (
   input  logic        clock,
   input  logic [31:0] timestamp,
   output logic [11:0] year,
   output logic [3:0]  month,
   output logic [4:0]  day,
   output logic [4:0]  hour,
   output logic [5:0]  minute,
   output logic [5:0]  second
);
   import utdc_pkg::*;

   logic [31:0] ts_a_ff;
   logic [15:0] days_a_ff, days_b_ff, days_c_ff;
   logic [16:0] rem_b_ff, rem_c_ff;
   logic [7:0]  est_b_ff, k_c_ff;
   logic [10:0] tm_c_ff, tm_d_ff;
   logic [4:0]  hour_d_ff, hour_e_ff;
   logic [5:0]  sec_d_ff, sec_e_ff, min_e_ff;
   logic [8:0]  rem_d_ff;
   logic        lp_d_ff;
   logic [11:0] year_d_ff, year_e_ff;
   logic [3:0]  month_e_ff;
   logic [4:0]  day_e_ff;

   logic [50:0] pa;
   logic [36:0] pb;
   logic [30:0] pc;
   logic [21:0] pd;
   logic [31:0] rem_full;
   logic [7:0]  k_in;
   logic [3:0]  m_in;

   // days = floor(ts / 86400)
   assign pa = {26'd0, timestamp[31:7]} * 51'd50903317;
   always_ff @(posedge clock) begin
      ts_a_ff   <= timestamp;
      days_a_ff <= pa[50:35];
   end

   assign rem_full = ts_a_ff - {16'd0, days_a_ff} * 32'd86400;
   assign pb = {19'd0, days_a_ff, 2'b10} * 37'd367469;
   always_ff @(posedge clock) begin
      days_b_ff <= days_a_ff;
      rem_b_ff  <= rem_full[16:0];
      est_b_ff  <= pb[36:29];
   end

   assign pc = {16'd0, rem_b_ff[16:2]} * 31'd34953;
   always_comb begin
      priority if ({1'b0, days_b_ff} >= year_start(est_b_ff + 8'd1)) begin
         k_in = est_b_ff + 8'd1;
      end else if ({1'b0, days_b_ff} < year_start(est_b_ff)) begin
         k_in = est_b_ff - 8'd1;
      end else begin
         k_in = est_b_ff;
      end
   end
   always_ff @(posedge clock) begin
      days_c_ff <= days_b_ff;
      rem_c_ff  <= rem_b_ff;
      tm_c_ff   <= pc[29:19];
      k_c_ff    <= k_in;
   end

   assign pd = {11'd0, tm_c_ff} * 22'd1093;
   always_ff @(posedge clock) begin
      tm_d_ff   <= tm_c_ff;
      hour_d_ff <= pd[20:16];
      sec_d_ff  <= 6'(rem_c_ff - 17'({6'd0, tm_c_ff} * 17'd60));
      rem_d_ff  <= 9'({1'b0, days_c_ff} - year_start(k_c_ff));
      lp_d_ff   <= is_leap(EPOCH_YEAR + {4'd0, k_c_ff});
      year_d_ff <= EPOCH_YEAR + {4'd0, k_c_ff};
   end

   always_comb begin
      m_in = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (rem_d_ff >= month_start(4'(i), lp_d_ff)) begin
            m_in = 4'(i);
         end
      end
   end
   always_ff @(posedge clock) begin
      hour_e_ff  <= hour_d_ff;
      sec_e_ff   <= sec_d_ff;
      min_e_ff   <= 6'(tm_d_ff - 11'({6'd0, hour_d_ff} * 11'd60));
      year_e_ff  <= year_d_ff;
      month_e_ff <= m_in + 4'd1;
      day_e_ff   <= 5'(rem_d_ff - month_start(m_in, lp_d_ff) + 9'd1);
   end

   assign year   = year_e_ff;
   assign month  = month_e_ff;
   assign day    = day_e_ff;
   assign hour   = hour_e_ff;
   assign minute = min_e_ff;
   assign second = sec_e_ff;
endmodule

@@ rtl/core/utdc_checker.sv @@
// Port-level checker for the unix time / date converter, bound to the top.
// Depends on unix_time_date_converter_macros.svh.
`include "unix_time_date_converter_macros.svh"

module utdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_command,
   input logic        rsp_valid,
   input logic [31:0] rsp_out_timestamp,
   input logic [11:0] rsp_out_year
);
   `UTDC_ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")
   `UTDC_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(start, 5), "result without request")
   `UTDC_ASSERT(a_d2s_zero, clock, reset, (rsp_valid && !$past(req_command, 5)) |-> (rsp_out_year == 12'd0), "date fields not cleared")
   `UTDC_ASSERT(a_s2d_zero, clock, reset, (rsp_valid && $past(req_command, 5)) |-> (rsp_out_timestamp == 32'd0), "timestamp not cleared")
endmodule

bind unix_time_date_converter utdc_checker u_utdc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_out_timestamp (rsp_out_timestamp),
   .rsp_out_year      (rsp_out_year)
);
